>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion forms used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_SAME(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/lhps_pkg.sv
// ----------------------------------------------------------------------------
// LED / haptic pattern sequencer package
// Types, pattern ROM and helper functions.
// ----------------------------------------------------------------------------
package lhps_pkg;

	localparam int MAX_STEPS      = 8;
	localparam int PATTERN_COUNT  = 8;
	localparam int TABLE_PATTERNS = 8;
	localparam int TABLE_SLOTS    = 4;
	localparam int PAT_IDX_W      = $clog2(TABLE_PATTERNS);
	localparam int SLOT_W         = $clog2(TABLE_SLOTS);
	localparam int LEN_W          = 5;
	localparam logic [8:0]  FULL_SCALE  = 9'd256;
	localparam logic [15:0] ELAPSED_MAX = 16'hFFFF;

	typedef enum logic [1:0] {
		OP_TICK    = 2'd0,
		OP_TRIGGER = 2'd1,
		OP_CANCEL  = 2'd2,
		OP_SET_LED = 2'd3
	} lhps_op_t;

	typedef struct packed {
		logic [7:0]  r;
		logic [7:0]  g;
		logic [7:0]  b;
		logic [7:0]  buzz;
		logic [15:0] ms;
	} lhps_step_t;

	typedef struct packed {
		logic        active;
		logic [3:0]  pattern_id;
		logic [2:0]  step_index;
		logic [15:0] elapsed_ms;
		logic [8:0]  held_intensity;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [7:0]  haptic_level;
	} lhps_state_t;

	typedef struct packed {
		logic [1:0] op;
		logic [3:0] pattern_kind;
		logic [8:0] intensity;
		logic [7:0] red_in;
		logic [7:0] green_in;
		logic [7:0] blue_in;
	} lhps_cmd_t;

	localparam lhps_step_t ROM [TABLE_PATTERNS][TABLE_SLOTS] = '{
		'{'{8'd0, 8'd255, 8'd0, 8'd200, 16'd100}, '{8'd0, 8'd255, 8'd0, 8'd0, 16'd100},
		  '{8'd0, 8'd255, 8'd0, 8'd150, 16'd80},  '{8'd0, 8'd0, 8'd0, 8'd0, 16'd0}},
		'{'{8'd0, 8'd0, 8'd0, 8'd200, 16'd100},   '{8'd0, 8'd0, 8'd0, 8'd0, 16'd100},
		  '{8'd0, 8'd0, 8'd0, 8'd200, 16'd100},   '{8'd0, 8'd0, 8'd0, 8'd0, 16'd0}},
		'{'{8'd0, 8'd255, 8'd0, 8'd0, 16'd150},   '{8'd0, 8'd0, 8'd0, 8'd0, 16'd0},
		  '{8'd0, 8'd0, 8'd0, 8'd0, 16'd0},       '{8'd0, 8'd0, 8'd0, 8'd0, 16'd0}},
		'{'{8'd0, 8'd0, 8'd0, 8'd180, 16'd200},   '{8'd0, 8'd0, 8'd0, 8'd0, 16'd100},
		  '{8'd0, 8'd0, 8'd0, 8'd120, 16'd150},   '{8'd0, 8'd0, 8'd0, 8'd0, 16'd0}},
		'{'{8'd255, 8'd255, 8'd0, 8'd0, 16'd300}, '{8'd0, 8'd0, 8'd0, 8'd0, 16'd200},
		  '{8'd255, 8'd255, 8'd0, 8'd0, 16'd300}, '{8'd0, 8'd0, 8'd0, 8'd0, 16'd0}},
		'{'{8'd0, 8'd0, 8'd255, 8'd100, 16'd200}, '{8'd0, 8'd0, 8'd0, 8'd0, 16'd0},
		  '{8'd0, 8'd0, 8'd0, 8'd0, 16'd0},       '{8'd0, 8'd0, 8'd0, 8'd0, 16'd0}},
		'{'{8'd255, 8'd0, 8'd0, 8'd100, 16'd200}, '{8'd0, 8'd0, 8'd0, 8'd0, 16'd0},
		  '{8'd0, 8'd0, 8'd0, 8'd0, 16'd0},       '{8'd0, 8'd0, 8'd0, 8'd0, 16'd0}},
		'{'{8'd255, 8'd0, 8'd0, 8'd255, 16'd200}, '{8'd0, 8'd0, 8'd0, 8'd0, 16'd100},
		  '{8'd255, 8'd0, 8'd0, 8'd255, 16'd200}, '{8'd0, 8'd0, 8'd0, 8'd0, 16'd0}}
	};

	localparam logic [LEN_W-1:0] ROM_LEN [TABLE_PATTERNS] = '{
		5'd3, 5'd3, 5'd1, 5'd3, 5'd3, 5'd1, 5'd1, 5'd3
	};

	function automatic logic [8:0] clamp_scale(input logic [8:0] v);
		return (v > FULL_SCALE) ? FULL_SCALE : v;
	endfunction

	function automatic logic [PAT_IDX_W-1:0] pat_idx(input logic [3:0] id);
		logic [3:0] d;
		d = id - 4'd1;
		return d[PAT_IDX_W-1:0];
	endfunction

	// number of steps played for a kind; zero for none or unknown
	function automatic logic [LEN_W-1:0] steps_of(input logic [3:0] id);
		logic [LEN_W-1:0] n;
		n = '0;
		if (id != 4'd0 && int'(id) <= PATTERN_COUNT && int'(id) <= TABLE_PATTERNS) begin
			n = ROM_LEN[pat_idx(id)];
			if (int'(n) > MAX_STEPS)
				n = LEN_W'(MAX_STEPS);
		end
		return n;
	endfunction

	// running sum of durations up to and including the given step
	function automatic logic [15:0] step_deadline(input logic [PAT_IDX_W-1:0] idx,
			input logic [2:0] step, input logic [LEN_W-1:0] total);
		logic [15:0] sum;
		sum = '0;
		for (int i = 0; i < TABLE_SLOTS; i++) begin
			if (i <= int'(step) && i < int'(total))
				sum = sum + ROM[idx][i].ms;
		end
		return sum;
	endfunction

	function automatic lhps_state_t cancel_all(input lhps_state_t s);
		lhps_state_t o;
		o = s;
		o.active       = 1'b0;
		o.pattern_id   = 4'd0;
		o.step_index   = 3'd0;
		o.red          = 8'd0;
		o.green        = 8'd0;
		o.blue         = 8'd0;
		o.haptic_level = 8'd0;
		return o;
	endfunction

	function automatic lhps_state_t show_step(input lhps_state_t s);
		lhps_state_t o;
		lhps_step_t  st;
		o = s;
		st = ROM[pat_idx(s.pattern_id)][s.step_index[SLOT_W-1:0]];
		o.red          = st.r;
		o.green        = st.g;
		o.blue         = st.b;
		o.haptic_level = st.buzz;
		return o;
	endfunction

endpackage

>>> hdl/lhps_if.sv
// ----------------------------------------------------------------------------
// LED / haptic pattern sequencer channels
// Command and result channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface lhps_cmd_if;
	logic       valid;
	logic       ready;
	logic [1:0] op;
	logic [3:0] pattern_kind;
	logic [8:0] intensity;
	logic [7:0] red_in;
	logic [7:0] green_in;
	logic [7:0] blue_in;

	modport source (output valid, op, pattern_kind, intensity, red_in, green_in, blue_in,
		input ready);
	modport sink (input valid, op, pattern_kind, intensity, red_in, green_in, blue_in,
		output ready);
endinterface

interface lhps_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] red_pwm;
	logic [7:0] green_pwm;
	logic [7:0] blue_pwm;
	logic [7:0] haptic_pwm;
	logic       running;
	logic [2:0] step_now;

	modport source (output valid, red_pwm, green_pwm, blue_pwm, haptic_pwm, running,
		step_now, input ready);
	modport sink (input valid, red_pwm, green_pwm, blue_pwm, haptic_pwm, running,
		step_now, output ready);
endinterface

>>> hdl/led_haptic_pattern_sequencer_core.sv
// ----------------------------------------------------------------------------
// LED / haptic pattern sequencer core
// A word accepted waits in the command register, then its result is registered.
// Throughput: one word per cycle unless the result channel stalls; the command
// and result registers each hold one word; input is taken while a result waits.
// Reset: sequencer idle, no result valid, brightness and intensity at full scale.
// ----------------------------------------------------------------------------
module led_haptic_pattern_sequencer_core (
	input  logic              clk,
	input  logic              arst_n,
	lhps_cmd_if.sink          cmd,
	lhps_rsp_if.source        rsp,
	input  logic              cfg_wen,
	input  logic [8:0]        cfg_wdata
);

	logic                   cmd_valid_s1;
	lhps_pkg::lhps_cmd_t    cmd_s1;
	lhps_pkg::lhps_state_t  state_q;
	lhps_pkg::lhps_state_t  state_d;
	logic [8:0]             brightness_q;
	logic                   rsp_valid_q;
	logic [7:0]             red_q;
	logic [7:0]             green_q;
	logic [7:0]             blue_q;
	logic [7:0]             haptic_q;
	logic                   running_q;
	logic [2:0]             step_q;
	logic                   s1_fire;
	logic [16:0]            prod_r;
	logic [16:0]            prod_g;
	logic [16:0]            prod_b;
	logic [16:0]            prod_h;

	assign s1_fire   = cmd_valid_s1 && (!rsp_valid_q || rsp.ready);
	assign cmd.ready = !cmd_valid_s1 || s1_fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid_s1 <= 1'b0;
		end else if (cmd.valid && cmd.ready) begin
			cmd_valid_s1 <= 1'b1;
		end else if (s1_fire) begin
			cmd_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			cmd_s1 <= '{op: cmd.op, pattern_kind: cmd.pattern_kind, intensity: cmd.intensity,
				red_in: cmd.red_in, green_in: cmd.green_in, blue_in: cmd.blue_in};
		end
	end

	lhps_update u_update (
		.cur (state_q),
		.cmd (cmd_s1),
		.nxt (state_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{held_intensity: lhps_pkg::FULL_SCALE, default: '0};
		end else if (s1_fire) begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			brightness_q <= lhps_pkg::FULL_SCALE;
		end else if (cfg_wen) begin
			brightness_q <= lhps_pkg::clamp_scale(cfg_wdata);
		end
	end

	assign prod_r = 17'(state_d.red) * 17'(brightness_q);
	assign prod_g = 17'(state_d.green) * 17'(brightness_q);
	assign prod_b = 17'(state_d.blue) * 17'(brightness_q);
	assign prod_h = 17'(state_d.haptic_level) * 17'(state_d.held_intensity);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (s1_fire) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			red_q     <= prod_r[15:8];
			green_q   <= prod_g[15:8];
			blue_q    <= prod_b[15:8];
			haptic_q  <= prod_h[15:8];
			running_q <= state_d.active;
			step_q    <= state_d.step_index;
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.red_pwm    = red_q;
	assign rsp.green_pwm  = green_q;
	assign rsp.blue_pwm   = blue_q;
	assign rsp.haptic_pwm = haptic_q;
	assign rsp.running    = running_q;
	assign rsp.step_now   = step_q;

endmodule

>>> hdl/lhps_update.sv
// ----------------------------------------------------------------------------
// LED / haptic pattern sequencer state update
// Next sequencer state for one command word.
// ----------------------------------------------------------------------------
module lhps_update (
	input  lhps_pkg::lhps_state_t cur,
	input  lhps_pkg::lhps_cmd_t   cmd,
	output lhps_pkg::lhps_state_t nxt
);

	logic [lhps_pkg::LEN_W-1:0]     total;
	logic [lhps_pkg::LEN_W-1:0]     kind_len;
	logic [lhps_pkg::LEN_W-1:0]     step_inc;
	logic [15:0]                    elapsed_inc;
	logic [15:0]                    end_ms;
	lhps_pkg::lhps_state_t          trig;

	always_comb begin
		total       = lhps_pkg::steps_of(cur.pattern_id);
		kind_len    = lhps_pkg::steps_of(cmd.pattern_kind);
		step_inc    = {2'b00, cur.step_index} + 5'd1;
		elapsed_inc = (cur.elapsed_ms != lhps_pkg::ELAPSED_MAX) ?
			cur.elapsed_ms + 16'd1 : cur.elapsed_ms;
		end_ms      = lhps_pkg::step_deadline(lhps_pkg::pat_idx(cur.pattern_id),
			cur.step_index, total);

		trig = lhps_pkg::cancel_all(cur);
		trig.active         = 1'b1;
		trig.pattern_id     = cmd.pattern_kind;
		trig.step_index     = 3'd0;
		trig.elapsed_ms     = 16'd0;
		trig.held_intensity = lhps_pkg::clamp_scale(cmd.intensity);
		trig = lhps_pkg::show_step(trig);

		nxt = cur;
		case (lhps_pkg::lhps_op_t'(cmd.op))
			lhps_pkg::OP_TICK: begin
				if (cur.active) begin
					if (total == '0) begin
						nxt = lhps_pkg::cancel_all(cur);
					end else begin
						nxt.elapsed_ms = elapsed_inc;
						if (elapsed_inc >= end_ms) begin
							nxt.step_index = step_inc[2:0];
							if (step_inc >= total)
								nxt = lhps_pkg::cancel_all(nxt);
							else
								nxt = lhps_pkg::show_step(nxt);
						end
					end
				end
			end
			lhps_pkg::OP_TRIGGER: begin
				if (kind_len == '0)
					nxt = lhps_pkg::cancel_all(cur);
				else
					nxt = trig;
			end
			lhps_pkg::OP_CANCEL: begin
				nxt = lhps_pkg::cancel_all(cur);
			end
			lhps_pkg::OP_SET_LED: begin
				nxt.red   = cmd.red_in;
				nxt.green = cmd.green_in;
				nxt.blue  = cmd.blue_in;
			end
			default: begin
				nxt = cur;
			end
		endcase
	end

endmodule

>>> hdl/lhps_checker.sv
// ----------------------------------------------------------------------------
// LED / haptic pattern sequencer checker
// Port-level properties of the result channel.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lhps_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       rsp_valid,
	input logic       rsp_ready,
	input logic       running,
	input logic [2:0] step_now,
	input logic [7:0] haptic_pwm
);

	`ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid, "result word dropped while stalled")
	`ASSERT_SAME(a_idle_step, clk, arst_n, rsp_valid && !running, step_now == 3'd0, "step index set while idle")
	`ASSERT_SAME(a_idle_buzz, clk, arst_n, rsp_valid && !running, haptic_pwm == 8'd0, "haptic on while idle")
	`ASSERT_SAME(a_step_range, clk, arst_n, rsp_valid && running, step_now < 3'd3, "step beyond pattern length")

endmodule

bind led_haptic_pattern_sequencer_core lhps_checker u_lhps_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.running    (rsp.running),
	.step_now   (rsp.step_now),
	.haptic_pwm (rsp.haptic_pwm)
);
